// File: hw/rtl/sefc_pkg.sv
// Shared types, constants, saturating arithmetic and the microprogram of the series core.
`timescale 1ns / 1ps

package sefc_pkg;

    // pi held to 62 fraction bits
    localparam logic [63:0] PI_Q62     = 64'hC90F_DAA2_2168_C234;
    localparam int          SQRT_STEPS = 20;
    localparam int          ARG_FRAC   = 24;
    localparam int          PC_W       = 6;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    // function codes
    localparam logic [2:0] FN_EXP  = 3'd0;
    localparam logic [2:0] FN_SIN  = 3'd1;
    localparam logic [2:0] FN_COS  = 3'd2;
    localparam logic [2:0] FN_SQRT = 3'd3;
    localparam logic [2:0] FN_LOG  = 3'd4;

    // microprogram labels
    localparam logic [PC_W-1:0] PC_EXP      = 6'd0;
    localparam logic [PC_W-1:0] PC_EXP_LOOP = 6'd2;
    localparam logic [PC_W-1:0] PC_SIN      = 6'd6;
    localparam logic [PC_W-1:0] PC_SIN_RED  = 6'd7;
    localparam logic [PC_W-1:0] PC_SIN_HALF = 6'd9;
    localparam logic [PC_W-1:0] PC_SIN_INIT = 6'd11;
    localparam logic [PC_W-1:0] PC_SIN_LOOP = 6'd15;
    localparam logic [PC_W-1:0] PC_SIN_END  = 6'd20;
    localparam logic [PC_W-1:0] PC_COS      = 6'd21;
    localparam logic [PC_W-1:0] PC_SQRT     = 6'd22;
    localparam logic [PC_W-1:0] PC_SQRT_LP  = 6'd24;
    localparam logic [PC_W-1:0] PC_LOG      = 6'd28;
    localparam logic [PC_W-1:0] PC_LOG_LOOP = 6'd34;
    localparam logic [PC_W-1:0] PC_ZERO     = 6'd39;

    typedef enum logic [3:0] {
        OP_NOP, OP_MOV, OP_ADD, OP_SUB, OP_SUBN, OP_ABS, OP_NEGP,
        OP_MUL, OP_DIV, OP_IDIV, OP_DONE
    } t_op;

    typedef enum logic [3:0] {
        SRC_X, SRC_SUM, SRC_TERM, SRC_T, SRC_SQ, SRC_ZERO, SRC_ONE,
        SRC_NEGONE, SRC_PI, SRC_TWOPI, SRC_HALFPI
    } t_src;

    typedef enum logic [2:0] {
        D_X, D_SUM, D_TERM, D_T, D_SQ
    } t_dst;

    typedef enum logic [1:0] {
        K_I, K_SIN, K_ODD, K_TWO
    } t_ksel;

    typedef enum logic [1:0] {
        CNT_KEEP, CNT_CLR, CNT_SET1, CNT_INC
    } t_cnt;

    typedef enum logic [2:0] {
        C_NEXT, C_ALWAYS, C_NGT, C_LE0, C_NNEG, C_ILT_SER, C_ILT_LOG, C_ILT_SQRT
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_src            a;
        t_src            b;
        t_dst            d;
        t_ksel           k;
        t_cnt            cnt;
        t_cond           cond;
        logic [PC_W-1:0] tgt;
    } t_word;

    typedef struct packed {
        logic        sat;
        logic [63:0] val;
    } t_sval;

    typedef struct packed {
        logic  done;
        t_sval res;
    } t_rsp;

    typedef struct packed {
        logic start;
        logic int_mode;
    } t_div_req;

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // clamp a magnitude and sign into the signed 64-bit range
    function automatic t_sval pack(input logic [63:0] m, input logic neg, input logic ovf);
        t_sval       r;
        logic [63:0] lim;
        lim = neg ? S64_MIN : S64_MAX;
        if (ovf || m > lim) begin
            r.sat = 1'b1;
            r.val = neg ? S64_MIN : S64_MAX;
        end else begin
            r.sat = 1'b0;
            r.val = neg ? (64'd0 - m) : m;
        end
        return r;
    endfunction

    function automatic t_sval sadd(input logic [63:0] a, input logic [63:0] b);
        t_sval       r;
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            r.sat = 1'b1;
            r.val = s[64] ? S64_MIN : S64_MAX;
        end else begin
            r.sat = 1'b0;
            r.val = s[63:0];
        end
        return r;
    endfunction

    function automatic t_word mk(input t_op op, input t_src a, input t_src b, input t_dst d,
                                 input t_ksel k, input t_cnt cnt, input t_cond cond,
                                 input logic [PC_W-1:0] tgt);
        t_word w;
        w.op   = op;
        w.a    = a;
        w.b    = b;
        w.d    = d;
        w.k    = k;
        w.cnt  = cnt;
        w.cond = cond;
        w.tgt  = tgt;
        return w;
    endfunction

    function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] func);
        logic [PC_W-1:0] p;
        case (func)
            FN_EXP:  p = PC_EXP;
            FN_SIN:  p = PC_SIN;
            FN_COS:  p = PC_COS;
            FN_SQRT: p = PC_SQRT;
            FN_LOG:  p = PC_LOG;
            default: p = PC_ZERO;
        endcase
        return p;
    endfunction

    // control store
    function automatic t_word uc_word(input logic [PC_W-1:0] pc);
        t_word w;
        case (pc)
            // exp: 1 + sum of term *= x/i
            6'd0:  w = mk(OP_MOV,  SRC_ONE,  SRC_ZERO,  D_SUM,  K_I,   CNT_SET1, C_NEXT, PC_ZERO);
            6'd1:  w = mk(OP_MOV,  SRC_ONE,  SRC_ZERO,  D_TERM, K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd2:  w = mk(OP_IDIV, SRC_X,    SRC_ZERO,  D_T,    K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd3:  w = mk(OP_MUL,  SRC_TERM, SRC_T,     D_TERM, K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd4:  w = mk(OP_ADD,  SRC_SUM,  SRC_TERM,  D_SUM,  K_I,   CNT_INC, C_ILT_SER,
                          PC_EXP_LOOP);
            6'd5:  w = mk(OP_DONE, SRC_SUM,  SRC_ZERO,  D_SUM,  K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            // sin: fold into 0..pi, then odd series
            6'd6:  w = mk(OP_ABS,  SRC_X,    SRC_ZERO,  D_X,    K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd7:  w = mk(OP_NOP,  SRC_X,    SRC_TWOPI, D_X,    K_I,   CNT_KEEP, C_NGT,
                          PC_SIN_HALF);
            6'd8:  w = mk(OP_SUB,  SRC_X,    SRC_TWOPI, D_X,    K_I,   CNT_KEEP, C_ALWAYS,
                          PC_SIN_RED);
            6'd9:  w = mk(OP_NOP,  SRC_X,    SRC_PI,    D_X,    K_I,   CNT_KEEP, C_NGT,
                          PC_SIN_INIT);
            6'd10: w = mk(OP_SUBN, SRC_X,    SRC_PI,    D_X,    K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd11: w = mk(OP_MOV,  SRC_X,    SRC_ZERO,  D_SUM,  K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd12: w = mk(OP_MOV,  SRC_X,    SRC_ZERO,  D_TERM, K_I,   CNT_SET1, C_NEXT, PC_ZERO);
            6'd13: w = mk(OP_MUL,  SRC_X,    SRC_X,     D_SQ,   K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd14: w = mk(OP_NEGP, SRC_SQ,   SRC_ZERO,  D_SQ,   K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd15: w = mk(OP_IDIV, SRC_SQ,   SRC_ZERO,  D_T,    K_SIN, CNT_KEEP, C_NEXT, PC_ZERO);
            6'd16: w = mk(OP_MUL,  SRC_TERM, SRC_T,     D_TERM, K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd17: w = mk(OP_ADD,  SRC_SUM,  SRC_TERM,  D_SUM,  K_I,   CNT_INC, C_ILT_SER,
                          PC_SIN_LOOP);
            6'd18: w = mk(OP_NOP,  SRC_SUM,  SRC_ZERO,  D_SUM,  K_I,   CNT_KEEP, C_NNEG,
                          PC_SIN_END);
            6'd19: w = mk(OP_NEGP, SRC_SUM,  SRC_ZERO,  D_SUM,  K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd20: w = mk(OP_DONE, SRC_SUM,  SRC_ZERO,  D_SUM,  K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            // cos: shift by pi/2 and run sin
            6'd21: w = mk(OP_ADD,  SRC_X,    SRC_HALFPI, D_X,   K_I,   CNT_KEEP, C_ALWAYS, PC_SIN);
            // sqrt: Newton steps from guess = x
            6'd22: w = mk(OP_NOP,  SRC_X,    SRC_ZERO,  D_X,    K_I,   CNT_KEEP, C_LE0, PC_ZERO);
            6'd23: w = mk(OP_MOV,  SRC_X,    SRC_ZERO,  D_SUM,  K_I,   CNT_CLR, C_NEXT, PC_ZERO);
            6'd24: w = mk(OP_DIV,  SRC_X,    SRC_SUM,   D_T,    K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd25: w = mk(OP_ADD,  SRC_SUM,  SRC_T,     D_T,    K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd26: w = mk(OP_IDIV, SRC_T,    SRC_ZERO,  D_SUM,  K_TWO, CNT_INC, C_ILT_SQRT,
                          PC_SQRT_LP);
            6'd27: w = mk(OP_DONE, SRC_SUM,  SRC_ZERO,  D_SUM,  K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            // log: atanh series on (x-1)/(x+1)
            6'd28: w = mk(OP_NOP,  SRC_X,    SRC_ZERO,  D_X,    K_I,   CNT_KEEP, C_LE0, PC_ZERO);
            6'd29: w = mk(OP_ADD,  SRC_X,    SRC_NEGONE, D_T,   K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd30: w = mk(OP_ADD,  SRC_X,    SRC_ONE,   D_SQ,   K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd31: w = mk(OP_DIV,  SRC_T,    SRC_SQ,    D_TERM, K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd32: w = mk(OP_MUL,  SRC_TERM, SRC_TERM,  D_SQ,   K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd33: w = mk(OP_MOV,  SRC_ZERO, SRC_ZERO,  D_SUM,  K_I,   CNT_SET1, C_NEXT, PC_ZERO);
            6'd34: w = mk(OP_IDIV, SRC_TERM, SRC_ZERO,  D_T,    K_ODD, CNT_KEEP, C_NEXT, PC_ZERO);
            6'd35: w = mk(OP_ADD,  SRC_SUM,  SRC_T,     D_SUM,  K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd36: w = mk(OP_MUL,  SRC_TERM, SRC_SQ,    D_TERM, K_I,   CNT_INC, C_ILT_LOG,
                          PC_LOG_LOOP);
            6'd37: w = mk(OP_ADD,  SRC_SUM,  SRC_SUM,   D_SUM,  K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            6'd38: w = mk(OP_DONE, SRC_SUM,  SRC_ZERO,  D_SUM,  K_I,   CNT_KEEP, C_NEXT, PC_ZERO);
            // zero result for bad domain or unused code
            default: w = mk(OP_DONE, SRC_ZERO, SRC_ZERO, D_SUM, K_I,  CNT_KEEP, C_NEXT, PC_ZERO);
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/sefc_mul.sv
// Fixed point multiplier: one 32x32 partial product per cycle, truncate and saturate.
`timescale 1ns / 1ps

module sefc_mul
    import sefc_pkg::*;
#(
    parameter int FRAC_BITS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output t_rsp        o_rsp
);

    logic         r_busy;
    logic         r_fin;
    logic         r_done;
    logic [1:0]   r_step;
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    logic [127:0] r_acc;
    t_sval        r_res;

    logic [31:0]  w_ha;
    logic [31:0]  w_hb;
    logic [63:0]  w_pp;
    logic [127:0] w_add;
    t_sval        w_pk;

    // select halves and align the partial product
    always_comb begin
        w_ha = r_step[0] ? r_ma[63:32] : r_ma[31:0];
        w_hb = r_step[1] ? r_mb[63:32] : r_mb[31:0];
        w_pp = w_ha * w_hb;
        case (r_step)
            2'd0:       w_add = {64'd0, w_pp};
            2'd1, 2'd2: w_add = {32'd0, w_pp, 32'd0};
            default:    w_add = {w_pp, 64'd0};
        endcase
        w_pk = pack(r_acc[FRAC_BITS+63:FRAC_BITS], r_neg, |r_acc[127:FRAC_BITS+64]);
    end

    // accumulate four partial products, then pack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ma   <= mag(i_a);
                r_mb   <= mag(i_b);
                r_neg  <= i_a[63] ^ i_b[63];
                r_acc  <= '0;
                r_step <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc  <= r_acc + w_add;
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_res  <= w_pk;
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

// File: hw/rtl/sefc_div.sv
// Restoring divider, one quotient bit per cycle: fixed point quotient or integer quotient.
`timescale 1ns / 1ps

module sefc_div
    import sefc_pkg::*;
#(
    parameter int FRAC_BITS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output t_rsp        o_rsp
);

    logic         r_busy;
    logic         r_fin;
    logic         r_done;
    logic [127:0] r_dvd;
    logic [63:0]  r_dsr;
    logic [64:0]  r_rem;
    logic [63:0]  r_q;
    logic [6:0]   r_k;
    logic         r_ovf;
    logic         r_neg;
    t_sval        r_res;

    logic [63:0]  w_n;
    logic [63:0]  w_d;
    logic [64:0]  w_rsh;
    logic         w_ge;
    logic [64:0]  w_rnx;

    // one restoring step
    always_comb begin
        w_n   = mag(i_a);
        w_d   = mag(i_b);
        w_rsh = {r_rem[63:0], r_dvd[127]};
        w_ge  = (w_rsh >= {1'b0, r_dsr});
        w_rnx = w_ge ? (w_rsh - {1'b0, r_dsr}) : w_rsh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_neg <= i_a[63] ^ i_b[63];
                if (w_d == 64'd0) begin
                    // zero divisor: clamp with the sign of the dividend
                    r_res  <= pack(64'd0, i_a[63], 1'b1);
                    r_done <= 1'b1;
                end else begin
                    r_dvd  <= i_req.int_mode ? {w_n, 64'd0} : ({64'd0, w_n} << FRAC_BITS);
                    r_k    <= i_req.int_mode ? 7'd63 : 7'd127;
                    r_dsr  <= w_d;
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_ovf  <= 1'b0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_rnx;
                r_dvd <= r_dvd << 1;
                r_q   <= {r_q[62:0], w_ge};
                if (w_ge && r_k[6]) begin
                    r_ovf <= 1'b1;
                end
                r_k <= r_k - 7'd1;
                if (r_k == 7'd0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_res  <= pack(r_q, r_neg, r_ovf);
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

// File: hw/rtl/series_elementary_functions_core.sv
// Top level: microcoded sequencer for exp, sin, cos, sqrt and log in signed fixed point.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------
//  input    | i_valid / o_ready  | i_func[2:0], i_arg[31:0]
//  output   | o_valid / i_ready  | o_value[63:0], o_saturated
//
// One item is worked at a time through the control store; multiply and divide steps wait
// for the shared unit in ST_WAIT, other steps advance directly. sin and cos first fold
// the argument by repeated subtraction of 2*pi. Codes without a function and bad domains
// finish with a zero result.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// A result held on a stalled output does not block the next transaction from entering.
`timescale 1ns / 1ps

module series_elementary_functions_core
    import sefc_pkg::*;
#(
    parameter int SERIES_TERMS = 20,
    parameter int LOG_TERMS    = 50,
    parameter int FRAC_BITS    = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_arg,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_value,
    output logic        o_saturated
);

    localparam int CNT_MAX0 = (SERIES_TERMS > LOG_TERMS) ? SERIES_TERMS : LOG_TERMS;
    localparam int CNT_MAX  = (CNT_MAX0 > SQRT_STEPS) ? CNT_MAX0 : SQRT_STEPS;
    localparam int CNT_W    = $clog2(CNT_MAX + 1);

    localparam logic [63:0] C_ONE    = 64'd1 << FRAC_BITS;
    localparam logic [63:0] C_NEGONE = 64'd0 - C_ONE;
    localparam logic [63:0] C_PI     = (PI_Q62 >> (62 - FRAC_BITS))
                                     + ((PI_Q62 >> (61 - FRAC_BITS)) & 64'd1);
    localparam logic [63:0] C_TWOPI  = (PI_Q62 >> (61 - FRAC_BITS))
                                     + ((PI_Q62 >> (60 - FRAC_BITS)) & 64'd1);
    localparam logic [63:0] C_HALFPI = (PI_Q62 >> (63 - FRAC_BITS))
                                     + ((PI_Q62 >> (62 - FRAC_BITS)) & 64'd1);

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAIT} t_state;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [63:0]     r_x, n_x;
    logic [63:0]     r_sum, n_sum;
    logic [63:0]     r_term, n_term;
    logic [63:0]     r_t, n_t;
    logic [63:0]     r_sq, n_sq;
    logic            r_sat, n_sat;
    logic            r_neg, n_neg;
    logic            r_ovalid, n_ovalid;
    logic [63:0]     r_value, n_value;
    logic            r_osat, n_osat;

    t_word           w;
    logic [63:0]     a_val;
    logic [63:0]     b_val;
    logic [15:0]     iw;
    logic [15:0]     kv;
    t_sval           alu;
    logic            neg_set;
    logic            neg_tgl;
    t_sval           wb;
    logic            adv;
    logic [CNT_W-1:0] cnt_nx;
    logic            jmp;
    logic            mul_start;
    t_div_req        div_req;
    logic [63:0]     div_b;
    t_rsp            mul_rsp;
    t_rsp            div_rsp;
    t_rsp            unit_rsp;

    // shared arithmetic units
    sefc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (a_val),
        .i_b     (b_val),
        .o_rsp   (mul_rsp)
    );

    sefc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_a     (a_val),
        .i_b     (div_b),
        .o_rsp   (div_rsp)
    );

    // decode the current control word and fetch operands
    always_comb begin
        w = uc_word(r_pc);
        case (w.a)
            SRC_X:      a_val = r_x;
            SRC_SUM:    a_val = r_sum;
            SRC_TERM:   a_val = r_term;
            SRC_T:      a_val = r_t;
            SRC_SQ:     a_val = r_sq;
            SRC_ONE:    a_val = C_ONE;
            SRC_NEGONE: a_val = C_NEGONE;
            SRC_PI:     a_val = C_PI;
            SRC_TWOPI:  a_val = C_TWOPI;
            SRC_HALFPI: a_val = C_HALFPI;
            default:    a_val = 64'd0;
        endcase
        case (w.b)
            SRC_X:      b_val = r_x;
            SRC_SUM:    b_val = r_sum;
            SRC_TERM:   b_val = r_term;
            SRC_T:      b_val = r_t;
            SRC_SQ:     b_val = r_sq;
            SRC_ONE:    b_val = C_ONE;
            SRC_NEGONE: b_val = C_NEGONE;
            SRC_PI:     b_val = C_PI;
            SRC_TWOPI:  b_val = C_TWOPI;
            SRC_HALFPI: b_val = C_HALFPI;
            default:    b_val = 64'd0;
        endcase

        // integer divisor from the step counter, or the constant 2
        iw = 16'(r_cnt);
        case (w.k)
            K_I:     kv = iw;
            K_SIN:   kv = (iw << 1) * ((iw << 1) + 16'd1);
            K_ODD:   kv = (iw << 1) - 16'd1;
            default: kv = 16'd2;
        endcase

        mul_start        = (r_state == ST_EXEC) && (w.op == OP_MUL);
        div_req.start    = (r_state == ST_EXEC) && ((w.op == OP_DIV) || (w.op == OP_IDIV));
        div_req.int_mode = (w.op == OP_IDIV);
        div_b            = (w.op == OP_IDIV) ? {48'd0, kv} : b_val;
        unit_rsp         = (w.op == OP_MUL) ? mul_rsp : div_rsp;
    end

    // combinational datapath operations
    always_comb begin
        neg_set = 1'b0;
        neg_tgl = 1'b0;
        case (w.op)
            OP_ADD:  alu = sadd(a_val, b_val);
            OP_SUB:  alu = '{sat: 1'b0, val: a_val - b_val};
            OP_SUBN: begin
                alu     = '{sat: 1'b0, val: a_val - b_val};
                neg_tgl = 1'b1;
            end
            OP_ABS: begin
                if (a_val[63]) begin
                    alu     = pack(mag(a_val), 1'b0, 1'b0);
                    neg_set = 1'b1;
                end else begin
                    alu = '{sat: 1'b0, val: a_val};
                end
            end
            OP_NEGP: alu = pack(mag(a_val), !a_val[63] && (a_val != 64'd0), 1'b0);
            default: alu = '{sat: 1'b0, val: a_val};
        endcase
    end

    // sequencer: next step, write back, output register
    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_cnt    = r_cnt;
        n_x      = r_x;
        n_sum    = r_sum;
        n_term   = r_term;
        n_t      = r_t;
        n_sq     = r_sq;
        n_sat    = r_sat;
        n_neg    = r_neg;
        n_ovalid = r_ovalid;
        n_value  = r_value;
        n_osat   = r_osat;
        adv      = 1'b0;
        wb       = alu;

        // drop the result once taken
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_x     = {{32{i_arg[31]}}, i_arg} << (FRAC_BITS - ARG_FRAC);
                    n_pc    = entry_pc(i_func);
                    n_sat   = 1'b0;
                    n_neg   = 1'b0;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (w.op)
                    OP_MUL, OP_DIV, OP_IDIV: n_state = ST_WAIT;
                    OP_DONE: begin
                        if (!r_ovalid || i_ready) begin
                            n_value  = a_val;
                            n_osat   = r_sat;
                            n_ovalid = 1'b1;
                            n_state  = ST_IDLE;
                        end
                    end
                    default: adv = 1'b1;
                endcase
            end
            ST_WAIT: begin
                if (unit_rsp.done) begin
                    adv     = 1'b1;
                    wb      = unit_rsp.res;
                    n_state = ST_EXEC;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // step counter update
        case (w.cnt)
            CNT_CLR:  cnt_nx = '0;
            CNT_SET1: cnt_nx = CNT_W'(1);
            CNT_INC:  cnt_nx = r_cnt + CNT_W'(1);
            default:  cnt_nx = r_cnt;
        endcase

        // branch condition
        case (w.cond)
            C_ALWAYS:   jmp = 1'b1;
            C_NGT:      jmp = !($signed(a_val) > $signed(b_val));
            C_LE0:      jmp = ($signed(a_val) <= 64'sd0);
            C_NNEG:     jmp = !r_neg;
            C_ILT_SER:  jmp = (cnt_nx < CNT_W'(SERIES_TERMS));
            C_ILT_LOG:  jmp = (cnt_nx < CNT_W'(LOG_TERMS));
            C_ILT_SQRT: jmp = (cnt_nx < CNT_W'(SQRT_STEPS));
            default:    jmp = 1'b0;
        endcase

        if (adv) begin
            n_cnt = cnt_nx;
            n_pc  = jmp ? w.tgt : PC_W'(r_pc + 1'b1);
            if (!(w.op inside {OP_NOP, OP_DONE})) begin
                n_sat = r_sat | wb.sat;
                case (w.d)
                    D_X:     n_x    = wb.val;
                    D_SUM:   n_sum  = wb.val;
                    D_TERM:  n_term = wb.val;
                    D_T:     n_t    = wb.val;
                    default: n_sq   = wb.val;
                endcase
            end
            if (neg_set) begin
                n_neg = 1'b1;
            end else if (neg_tgl) begin
                n_neg = !r_neg;
            end
        end
    end

    // hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_pc    <= n_pc;
        r_cnt   <= n_cnt;
        r_x     <= n_x;
        r_sum   <= n_sum;
        r_term  <= n_term;
        r_t     <= n_t;
        r_sq    <= n_sq;
        r_sat   <= n_sat;
        r_neg   <= n_neg;
        r_value <= n_value;
        r_osat  <= n_osat;
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = r_ovalid;
    assign o_value     = r_value;
    assign o_saturated = r_osat;

endmodule
